// File: rtl/core/sasl_pkg.sv
package sasl_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W = 64;
  localparam int SYM_W = 20;
  localparam int KIND_W = 8;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 3;
  localparam int HELD_W = 13;

  localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = '1;

  localparam logic [KIND_W-1:0] KIND_UPPER_B = 8'h42;
  localparam logic [KIND_W-1:0] KIND_LOWER_B = 8'h62;
  localparam logic [KIND_W-1:0] KIND_UPPER_D = 8'h44;
  localparam logic [KIND_W-1:0] KIND_LOWER_D = 8'h64;
  localparam logic [KIND_W-1:0] KIND_UPPER_R = 8'h52;
  localparam logic [KIND_W-1:0] KIND_LOWER_R = 8'h72;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_ADDR  = 3'd2,
    ST_DATA_SYM  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LK_START,
    S_LK_PROBE,
    S_INS_START,
    S_INS_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SYM_W-1:0]  sym;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    status_t            status;
    logic [SYM_W-1:0]   found_symbol;
    logic [ADDR_W-1:0]  distance;
    logic [HELD_W-1:0]  entries_held;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t result;
  } done_t;

  function automatic logic is_data_kind(input logic [KIND_W-1:0] kind);
    return kind == KIND_UPPER_B || kind == KIND_LOWER_B ||
           kind == KIND_UPPER_D || kind == KIND_LOWER_D ||
           kind == KIND_UPPER_R || kind == KIND_LOWER_R;
  endfunction

endpackage

// File: rtl/core/sasl_req_if.sv
interface sasl_req_if;
  logic                           valid;
  logic                           ready;
  logic [sasl_pkg::CMD_W-1:0]     command;
  logic [sasl_pkg::ADDR_W-1:0]    address;
  logic [sasl_pkg::KIND_W-1:0]    symbol_kind;
  logic [sasl_pkg::SYM_W-1:0]     symbol_id;

  modport source (output valid, command, address, symbol_kind, symbol_id, input ready);
  modport sink (input valid, command, address, symbol_kind, symbol_id, output ready);
endinterface

// File: rtl/core/sasl_rsp_if.sv
interface sasl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sasl_pkg::STATUS_W-1:0]  status;
  logic [sasl_pkg::SYM_W-1:0]     found_symbol;
  logic [sasl_pkg::ADDR_W-1:0]    distance;
  logic [sasl_pkg::HELD_W-1:0]    entries_held;

  modport source (output valid, status, found_symbol, distance, entries_held, input ready);
  modport sink (input valid, status, found_symbol, distance, entries_held, output ready);
endinterface

// File: rtl/core/sorted_address_symbol_lookup.sv
// Channel    Direction  Payload
// request    in         command, address, symbol_kind, symbol_id
// response   out        status, found_symbol, distance, entries_held
// cfg_write  in         lowest_kernel_address (write enable and data)
//
// A lookup runs one binary-search probe per registered read of the table memory,
// ending on an exact match or when the search window closes.
// An accepted insert moves each entry above the new address up one slot to open its slot,
// and writes straight into an empty table.
// Clear, rejected inserts and an empty lookup go straight to the result without using the table.
// Reset empties the table and zeroes the floor register; the memory is not swept.
// A stalled response holds its transaction while one more request is accepted and worked on.
module sorted_address_symbol_lookup (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_enable,
  input  logic [sasl_pkg::ADDR_W-1:0]  cfg_write_data,
  sasl_req_if.sink                     request,
  sasl_rsp_if.source                   response
);

  sasl_pkg::ram_req_t ram_req;
  sasl_pkg::entry_t   ram_rdata;
  sasl_pkg::done_t    done;
  logic               done_ready;

  sasl_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .request          (request),
    .ram_req          (ram_req),
    .ram_rdata        (ram_rdata),
    .done             (done),
    .done_ready       (done_ready)
  );

  sasl_ram #(
    .WIDTH (sasl_pkg::ENTRY_W),
    .DEPTH (sasl_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  sasl_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .done       (done),
    .done_ready (done_ready),
    .response   (response)
  );

endmodule

// File: rtl/core/sasl_ram.sv
module sasl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/sasl_engine.sv
module sasl_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_enable,
  input  logic [sasl_pkg::ADDR_W-1:0]  cfg_write_data,
  sasl_req_if.sink                     request,
  output sasl_pkg::ram_req_t           ram_req,
  input  sasl_pkg::entry_t             ram_rdata,
  output sasl_pkg::done_t              done,
  input  logic                         done_ready
);

  sasl_pkg::state_t                state, state_next;
  logic [sasl_pkg::ADDR_W-1:0]     lowest_kernel_address;
  logic [sasl_pkg::CNT_W-1:0]      total, total_next;
  logic [sasl_pkg::CNT_W-1:0]      lo, lo_next;
  logic [sasl_pkg::CNT_W-1:0]      hi, hi_next;
  logic [sasl_pkg::CNT_W-1:0]      mid, mid_next;
  logic [sasl_pkg::CNT_W-1:0]      ptr, ptr_next;
  logic [sasl_pkg::CNT_W:0]        mid_sum;
  logic [sasl_pkg::ADDR_W-1:0]     q_addr, q_addr_next;
  logic [sasl_pkg::SYM_W-1:0]      q_sym, q_sym_next;
  logic                            floor_valid, floor_valid_next;
  sasl_pkg::entry_t                floor_entry, floor_entry_next;
  sasl_pkg::status_t               res_status, res_status_next;
  logic                            bad_addr;

  assign bad_addr = request.address == '0 || request.address == sasl_pkg::ADDR_ALL_ONES ||
                    request.address < lowest_kernel_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sasl_pkg::S_IDLE;
      total <= '0;
      lowest_kernel_address <= '0;
    end else begin
      state <= state_next;
      total <= total_next;
      if (cfg_write_enable) begin
        lowest_kernel_address <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    mid <= mid_next;
    ptr <= ptr_next;
    q_addr <= q_addr_next;
    q_sym <= q_sym_next;
    floor_valid <= floor_valid_next;
    floor_entry <= floor_entry_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next = state;
    total_next = total;
    lo_next = lo;
    hi_next = hi;
    mid_next = mid;
    ptr_next = ptr;
    q_addr_next = q_addr;
    q_sym_next = q_sym;
    floor_valid_next = floor_valid;
    floor_entry_next = floor_entry;
    res_status_next = res_status;
    mid_sum = {1'b0, lo} + {1'b0, hi};
    request.ready = 1'b0;
    ram_req.we = 1'b0;
    ram_req.waddr = ptr[sasl_pkg::IDX_W-1:0];
    ram_req.wdata.addr = q_addr;
    ram_req.wdata.sym = q_sym;
    ram_req.raddr = mid[sasl_pkg::IDX_W-1:0];
    done.valid = 1'b0;
    done.result.status = res_status;
    done.result.found_symbol = floor_valid ? floor_entry.sym : '0;
    done.result.distance = floor_valid ? q_addr - floor_entry.addr : '0;
    done.result.entries_held = sasl_pkg::HELD_W'(total);

    unique case (state)
      sasl_pkg::S_IDLE: begin
        request.ready = 1'b1;
        if (request.valid) begin
          q_addr_next = request.address;
          q_sym_next = request.symbol_id;
          floor_valid_next = 1'b0;
          res_status_next = sasl_pkg::ST_OK;
          lo_next = '0;
          hi_next = total;
          ptr_next = total;
          state_next = sasl_pkg::S_FINISH;
          unique case (sasl_pkg::command_t'(request.command))
            sasl_pkg::CMD_INSERT: begin
              if (bad_addr) begin
                res_status_next = sasl_pkg::ST_BAD_ADDR;
              end else if (sasl_pkg::is_data_kind(request.symbol_kind)) begin
                res_status_next = sasl_pkg::ST_DATA_SYM;
              end else if (total >= sasl_pkg::CNT_W'(sasl_pkg::TABLE_DEPTH)) begin
                res_status_next = sasl_pkg::ST_FULL;
              end else begin
                state_next = sasl_pkg::S_INS_START;
              end
            end
            sasl_pkg::CMD_LOOKUP: begin
              if (total == '0) begin
                res_status_next = sasl_pkg::ST_NOT_FOUND;
              end else begin
                state_next = sasl_pkg::S_LK_START;
              end
            end
            sasl_pkg::CMD_CLEAR: begin
              total_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      sasl_pkg::S_LK_START: begin
        mid_next = mid_sum[sasl_pkg::CNT_W:1];
        ram_req.raddr = mid_next[sasl_pkg::IDX_W-1:0];
        state_next = sasl_pkg::S_LK_PROBE;
      end

      sasl_pkg::S_LK_PROBE: begin
        if (q_addr < ram_rdata.addr) begin
          hi_next = mid;
        end else if (q_addr > ram_rdata.addr) begin
          lo_next = mid + sasl_pkg::CNT_W'(1);
          floor_valid_next = 1'b1;
          floor_entry_next = ram_rdata;
        end else begin
          floor_valid_next = 1'b1;
          floor_entry_next = ram_rdata;
        end
        mid_sum = {1'b0, lo_next} + {1'b0, hi_next};
        mid_next = mid_sum[sasl_pkg::CNT_W:1];
        ram_req.raddr = mid_next[sasl_pkg::IDX_W-1:0];
        if (q_addr == ram_rdata.addr) begin
          res_status_next = sasl_pkg::ST_OK;
          state_next = sasl_pkg::S_FINISH;
        end else if (lo_next >= hi_next) begin
          res_status_next = floor_valid_next ? sasl_pkg::ST_OK : sasl_pkg::ST_NOT_FOUND;
          state_next = sasl_pkg::S_FINISH;
        end
      end

      sasl_pkg::S_INS_START: begin
        ram_req.raddr = sasl_pkg::IDX_W'(ptr - sasl_pkg::CNT_W'(1));
        if (ptr == '0) begin
          ram_req.we = 1'b1;
          total_next = total + sasl_pkg::CNT_W'(1);
          state_next = sasl_pkg::S_FINISH;
        end else begin
          state_next = sasl_pkg::S_INS_SCAN;
        end
      end

      sasl_pkg::S_INS_SCAN: begin
        ram_req.we = 1'b1;
        ram_req.raddr = sasl_pkg::IDX_W'(ptr - sasl_pkg::CNT_W'(2));
        if (ram_rdata.addr > q_addr) begin
          ram_req.wdata = ram_rdata;
          ptr_next = ptr - sasl_pkg::CNT_W'(1);
          if (ptr == sasl_pkg::CNT_W'(1)) begin
            state_next = sasl_pkg::S_INS_START;
          end
        end else begin
          total_next = total + sasl_pkg::CNT_W'(1);
          state_next = sasl_pkg::S_FINISH;
        end
      end

      sasl_pkg::S_FINISH: begin
        done.valid = 1'b1;
        if (done_ready) begin
          state_next = sasl_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sasl_pkg::S_IDLE;
      end
    endcase
  end

  a_total_in_range: assert property (@(posedge clk) disable iff (rst)
    total <= sasl_pkg::CNT_W'(sasl_pkg::TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    state == sasl_pkg::S_LK_PROBE |-> lo < hi && mid >= lo && mid < hi)
    else $error("probe index outside the search window");

  a_scan_pointer: assert property (@(posedge clk) disable iff (rst)
    state == sasl_pkg::S_INS_SCAN |-> ptr != '0 && ptr <= total)
    else $error("insert scan pointer out of range");

  a_write_only_on_insert: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> state == sasl_pkg::S_INS_START || state == sasl_pkg::S_INS_SCAN)
    else $error("table write outside an insert");

  a_finish_returns_idle: assert property (@(posedge clk) disable iff (rst)
    state == sasl_pkg::S_FINISH && done_ready |=> state == sasl_pkg::S_IDLE)
    else $error("result handed off but engine did not return to idle");

endmodule

// File: rtl/core/sasl_out_stage.sv
module sasl_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  sasl_pkg::done_t  done,
  output logic             done_ready,
  sasl_rsp_if.source       response
);

  sasl_pkg::result_t held;

  assign done_ready = !response.valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (done_ready) begin
      response.valid <= done.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done.valid) begin
      held <= done.result;
    end
  end

  assign response.status = held.status;
  assign response.found_symbol = held.found_symbol;
  assign response.distance = held.distance;
  assign response.entries_held = held.entries_held;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [sasl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [sasl_pkg::KIND_W-1:0] KIND_TEXT = 8'h54;
  localparam logic [sasl_pkg::ADDR_W-1:0] KERNEL_FLOOR = 64'h00FF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst;
  logic cfg_write_enable;
  logic [sasl_pkg::ADDR_W-1:0] cfg_write_data;
  logic [sasl_pkg::ADDR_W-1:0] random_floor;

  sasl_req_if req_ch ();
  sasl_rsp_if rsp_ch ();

  sorted_address_symbol_lookup dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .request          (req_ch),
    .response         (rsp_ch)
  );

  logic [sasl_pkg::ADDR_W-1:0] shadow_addr [sasl_pkg::TABLE_DEPTH];
  logic [sasl_pkg::SYM_W-1:0]  shadow_sym [sasl_pkg::TABLE_DEPTH];
  int                          shadow_count = 0;
  logic [sasl_pkg::ADDR_W-1:0] shadow_floor = '0;

  logic [sasl_pkg::KIND_W-1:0] data_kinds [6] = '{
    sasl_pkg::KIND_UPPER_B, sasl_pkg::KIND_LOWER_B, sasl_pkg::KIND_UPPER_D,
    sasl_pkg::KIND_LOWER_D, sasl_pkg::KIND_UPPER_R, sasl_pkg::KIND_LOWER_R};

  sasl_pkg::result_t pending_results [$];
  int                error_count = 0;
  int                src_idle_pct = 0;
  int                sink_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  function automatic sasl_pkg::result_t predict_response(
      input logic [sasl_pkg::CMD_W-1:0] cmd,
      input logic [sasl_pkg::ADDR_W-1:0] addr,
      input logic [sasl_pkg::KIND_W-1:0] kind,
      input logic [sasl_pkg::SYM_W-1:0] id);
    sasl_pkg::result_t res;
    int      pos;
    int      lo;
    int      hi;
    int      mid;
    logic    is_data;
    logic    hit;
    res = '0;
    res.status = sasl_pkg::ST_OK;
    case (cmd)
      sasl_pkg::CMD_INSERT: begin
        is_data = 1'b0;
        foreach (data_kinds[i]) begin
          if (kind == data_kinds[i]) is_data = 1'b1;
        end
        if (addr == '0 || addr == sasl_pkg::ADDR_ALL_ONES || addr < shadow_floor) begin
          res.status = sasl_pkg::ST_BAD_ADDR;
        end else if (is_data) begin
          res.status = sasl_pkg::ST_DATA_SYM;
        end else if (shadow_count >= sasl_pkg::TABLE_DEPTH) begin
          res.status = sasl_pkg::ST_FULL;
        end else begin
          pos = shadow_count;
          while (pos > 0 && shadow_addr[pos-1] > addr) pos--;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_addr[i] = shadow_addr[i-1];
            shadow_sym[i] = shadow_sym[i-1];
          end
          shadow_addr[pos] = addr;
          shadow_sym[pos] = id;
          shadow_count++;
        end
      end
      sasl_pkg::CMD_LOOKUP: begin
        lo = 0;
        hi = shadow_count;
        hit = 1'b0;
        while (lo < hi && !hit) begin
          mid = lo + (hi - lo) / 2;
          if (addr < shadow_addr[mid]) begin
            hi = mid;
          end else if (addr > shadow_addr[mid]) begin
            lo = mid + 1;
          end else begin
            hit = 1'b1;
            res.found_symbol = shadow_sym[mid];
          end
        end
        if (!hit) begin
          if (lo >= 1) begin
            res.found_symbol = shadow_sym[lo-1];
            res.distance = addr - shadow_addr[lo-1];
          end else begin
            res.status = sasl_pkg::ST_NOT_FOUND;
          end
        end
      end
      sasl_pkg::CMD_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    res.entries_held = sasl_pkg::HELD_W'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    sasl_pkg::result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response transaction with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
        if (rsp_ch.found_symbol !== want.found_symbol)
          report_mismatch($sformatf("found_symbol got %h want %h",
                                    rsp_ch.found_symbol, want.found_symbol));
        if (rsp_ch.distance !== want.distance)
          report_mismatch($sformatf("distance got %h want %h",
                                    rsp_ch.distance, want.distance));
        if (rsp_ch.entries_held !== want.entries_held)
          report_mismatch($sformatf("entries_held got %0d want %0d",
                                    rsp_ch.entries_held, want.entries_held));
      end
    end
  end

  task automatic send_item(input logic [sasl_pkg::CMD_W-1:0] cmd,
                           input logic [sasl_pkg::ADDR_W-1:0] addr,
                           input logic [sasl_pkg::KIND_W-1:0] kind,
                           input logic [sasl_pkg::SYM_W-1:0] id);
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.address <= addr;
    req_ch.symbol_kind <= kind;
    req_ch.symbol_id <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_response(cmd, addr, kind, id));
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_floor(input logic [sasl_pkg::ADDR_W-1:0] value);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    shadow_floor = value;
  endtask

  function automatic logic [sasl_pkg::ADDR_W-1:0] pick_address(
      input logic [sasl_pkg::ADDR_W-1:0] base);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return base + 64'($urandom_range(0, 4095));
    if (sel < 70) begin
      if (shadow_count == 0) return base;
      return shadow_addr[$urandom_range(0, shadow_count - 1)] +
             ((sel < 60) ? 64'd0 : 64'($urandom_range(1, 3)));
    end
    if (sel < 80) return {$urandom, $urandom};
    if (sel < 85) return '0;
    if (sel < 90) return sasl_pkg::ADDR_ALL_ONES;
    if (sel < 95) return shadow_floor - 64'd1;
    return shadow_floor;
  endfunction

  task automatic test_empty_lookup();
    send_item(sasl_pkg::CMD_LOOKUP, '0, KIND_TEXT, 20'h0);
    send_item(sasl_pkg::CMD_LOOKUP, sasl_pkg::ADDR_ALL_ONES, 8'hFF, 20'hFFFFF);
    wait_drain();
  endtask

  task automatic test_bad_addresses();
    set_floor(KERNEL_FLOOR);
    send_item(sasl_pkg::CMD_INSERT, '0, KIND_TEXT, 20'h00001);
    send_item(sasl_pkg::CMD_INSERT, sasl_pkg::ADDR_ALL_ONES, KIND_TEXT, 20'h00002);
    send_item(sasl_pkg::CMD_INSERT, KERNEL_FLOOR - 64'd1, KIND_TEXT, 20'h00003);
    send_item(sasl_pkg::CMD_INSERT, KERNEL_FLOOR, KIND_TEXT, 20'hFFFFF);
    wait_drain();
  endtask

  task automatic test_data_kinds();
    foreach (data_kinds[i])
      send_item(sasl_pkg::CMD_INSERT, KERNEL_FLOOR + 64'h100, data_kinds[i], 20'h12345);
    send_item(sasl_pkg::CMD_INSERT, '0, sasl_pkg::KIND_LOWER_D, 20'h54321);
    wait_drain();
  endtask

  task automatic test_insert_and_lookup();
    send_item(sasl_pkg::CMD_INSERT, KERNEL_FLOOR + 64'h1000, KIND_TEXT, 20'hAAAAA);
    send_item(sasl_pkg::CMD_INSERT, KERNEL_FLOOR + 64'h1000, 8'h00, 20'h55555);
    send_item(sasl_pkg::CMD_INSERT, KERNEL_FLOOR + 64'h2000, 8'hFF, 20'h0F0F0);
    send_item(sasl_pkg::CMD_LOOKUP, KERNEL_FLOOR + 64'h1000, 8'h00, 20'h0);
    send_item(sasl_pkg::CMD_LOOKUP, KERNEL_FLOOR + 64'h1800, 8'h00, 20'h0);
    send_item(sasl_pkg::CMD_LOOKUP, KERNEL_FLOOR + 64'h2000, 8'h00, 20'h0);
    send_item(sasl_pkg::CMD_LOOKUP, KERNEL_FLOOR - 64'd1, 8'h00, 20'h0);
    send_item(sasl_pkg::CMD_LOOKUP, sasl_pkg::ADDR_ALL_ONES, 8'h00, 20'h0);
    wait_drain();
  endtask

  task automatic test_unused_command_and_clear();
    send_item(CMD_UNUSED, KERNEL_FLOOR + 64'h40, KIND_TEXT, 20'h77777);
    send_item(sasl_pkg::CMD_CLEAR, '0, 8'h00, 20'h0);
    send_item(sasl_pkg::CMD_LOOKUP, KERNEL_FLOOR + 64'h1000, 8'h00, 20'h0);
    send_item(CMD_UNUSED, sasl_pkg::ADDR_ALL_ONES, 8'hFF, 20'hFFFFF);
    wait_drain();
  endtask

  task automatic test_floor_extremes();
    set_floor(sasl_pkg::ADDR_ALL_ONES);
    send_item(sasl_pkg::CMD_INSERT, sasl_pkg::ADDR_ALL_ONES - 64'd1, KIND_TEXT, 20'h11111);
    wait_drain();
    set_floor('0);
    send_item(sasl_pkg::CMD_INSERT, 64'd1, KIND_TEXT, 20'h22222);
    send_item(sasl_pkg::CMD_LOOKUP, sasl_pkg::ADDR_ALL_ONES, 8'h00, 20'h0);
    wait_drain();
  endtask

  task automatic test_random(input int items, input int src_pct, input int sink_pct,
                             input logic [sasl_pkg::ADDR_W-1:0] floor_value,
                             input logic [sasl_pkg::ADDR_W-1:0] base);
    int                          sel;
    logic [sasl_pkg::KIND_W-1:0] kind;
    set_floor(floor_value);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(0, 99);
      kind = sasl_pkg::KIND_W'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) kind = data_kinds[$urandom_range(0, 5)];
      if (shadow_count >= 60) begin
        send_item(sasl_pkg::CMD_CLEAR, {$urandom, $urandom}, kind,
                  sasl_pkg::SYM_W'($urandom));
      end else if (sel < 42) begin
        send_item(sasl_pkg::CMD_INSERT, pick_address(base), kind,
                  sasl_pkg::SYM_W'($urandom));
      end else if (sel < 92) begin
        send_item(sasl_pkg::CMD_LOOKUP, pick_address(base), kind,
                  sasl_pkg::SYM_W'($urandom));
      end else if (sel < 96) begin
        send_item(sasl_pkg::CMD_CLEAR, {$urandom, $urandom}, kind,
                  sasl_pkg::SYM_W'($urandom));
      end else begin
        send_item(CMD_UNUSED, pick_address(base), kind, sasl_pkg::SYM_W'($urandom));
      end
    end
    wait_drain();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write_enable <= 1'b0;
    cfg_write_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.command <= sasl_pkg::CMD_INSERT;
    req_ch.address <= '0;
    req_ch.symbol_kind <= '0;
    req_ch.symbol_id <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 19;
    sink_idle_pct = 85;
    test_empty_lookup();
    test_bad_addresses();
    test_data_kinds();
    test_insert_and_lookup();
    test_unused_command_and_clear();
    test_floor_extremes();

    test_random(220, 19, 85, '0, 64'hFFFF_FFFF_8000_0000);
    test_random(220, 85, 19, KERNEL_FLOOR, KERNEL_FLOOR - 64'd1000);
    random_floor = {1'b0, 31'($urandom), 32'($urandom)} + 64'd4096;
    test_random(210, 0, 0, random_floor, random_floor);

    wait_drain();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
